[sv/mtd_pkg.sv]
// mtd_pkg: shared types, codes and character helpers for the mail transfer decoder
// no dependencies; imported by mtd_decode, mtd_out_reg and mail_transfer_decoder
package mtd_pkg;

    localparam int BYTE_W     = 8;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_DECODE_MODE      = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNDERSCORE_SPACE = 1'd1;

    localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_B64  = 2'd2;

    localparam logic [1:0] QP_IDLE     = 2'd0;
    localparam logic [1:0] QP_AFTER_EQ = 2'd1;
    localparam logic [1:0] QP_AFTER_HI = 2'd2;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;

    typedef struct packed {
        logic [1:0] b64_phase;
        logic [5:0] b64_carry;
        logic [1:0] qp_escape_step;
        logic [3:0] qp_high_nibble;
        logic       drop_rest;
    } t_seg_state;

    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              seg_done;
    } t_result;

    // bit 4 set for a non-hex byte
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [4:0] h;
        h = 5'h10;
        if (c inside {["0":"9"]}) begin
            h = 5'(c - 8'h30);
        end else if (c inside {["a":"f"]}) begin
            h = 5'(c - 8'h57);
        end else if (c inside {["A":"F"]}) begin
            h = 5'(c - 8'h37);
        end
        return h;
    endfunction

    // bit 6 set for a byte outside the alphabet
    function automatic logic [6:0] b64_value(input logic [BYTE_W-1:0] c);
        logic [6:0] v;
        v = 7'h40;
        if (c == CH_PLUS) begin
            v = 7'd62;
        end else if (c == CH_SLASH) begin
            v = 7'd63;
        end else if (c inside {["A":"Z"]}) begin
            v = 7'(c - 8'h41);
        end else if (c inside {["a":"z"]}) begin
            v = 7'(c - 8'h47);
        end else if (c inside {["0":"9"]}) begin
            v = 7'(c + 8'h04);
        end else if (c == CH_EQ) begin
            v = 7'd0;
        end
        return v;
    endfunction

endpackage

[sv/mtd_decode.sv]
// mtd_decode: per-segment decoder state and the one-step decode of a word
// depends on mtd_pkg
module mtd_decode import mtd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    input  logic [MODE_W-1:0] i_mode,
    input  logic              i_underscore_space,
    output t_result           o_result
);

    t_seg_state r_state;
    t_seg_state n_state;

    logic              got;
    logic [BYTE_W-1:0] dec;
    logic [4:0]        hex;
    logic [6:0]        sextet;

    always_comb begin
        n_state = r_state;
        got     = 1'b0;
        dec     = '0;
        hex     = hex_digit(i_byte);
        sextet  = b64_value(i_byte);
        if (!r_state.drop_rest) begin
            case (i_mode)
                MODE_QP: begin
                    case (r_state.qp_escape_step)
                        QP_AFTER_EQ: begin
                            if (i_byte == CH_LF || i_byte == CH_NUL) begin
                                n_state.drop_rest      = 1'b1;
                                n_state.qp_escape_step = QP_IDLE;
                            end else begin
                                n_state.qp_high_nibble = hex[4] ? 4'hF : hex[3:0];
                                n_state.qp_escape_step = QP_AFTER_HI;
                            end
                        end
                        QP_AFTER_HI: begin
                            n_state.qp_escape_step = QP_IDLE;
                            if (i_byte == CH_NUL) begin
                                n_state.drop_rest = 1'b1;
                            end else begin
                                got = 1'b1;
                                dec = hex[4] ? 8'hFF : {r_state.qp_high_nibble, hex[3:0]};
                            end
                        end
                        default: begin
                            if (i_byte == CH_NUL) begin
                                n_state.drop_rest = 1'b1;
                            end else if (i_byte == CH_EQ) begin
                                n_state.qp_escape_step = QP_AFTER_EQ;
                            end else begin
                                got = 1'b1;
                                dec = (i_underscore_space && i_byte == CH_UNDER)
                                    ? CH_SPACE : i_byte;
                            end
                        end
                    endcase
                end
                MODE_B64: begin
                    if (i_byte == CH_NUL) begin
                        n_state.drop_rest = 1'b1;
                    end else if (!sextet[6]) begin
                        case (r_state.b64_phase)
                            2'd0: begin
                                n_state.b64_carry = sextet[5:0];
                                n_state.b64_phase = 2'd1;
                            end
                            2'd1: begin
                                got = 1'b1;
                                dec = {r_state.b64_carry, sextet[5:4]};
                                n_state.b64_carry = {2'b00, sextet[3:0]};
                                n_state.b64_phase = 2'd2;
                            end
                            2'd2: begin
                                got = 1'b1;
                                dec = {r_state.b64_carry[3:0], sextet[5:2]};
                                n_state.b64_carry = {4'b0000, sextet[1:0]};
                                n_state.b64_phase = 2'd3;
                            end
                            default: begin
                                got = 1'b1;
                                dec = {r_state.b64_carry[1:0], sextet[5:0]};
                                n_state.b64_carry = '0;
                                n_state.b64_phase = 2'd0;
                            end
                        endcase
                    end
                end
                default: begin
                    if (i_byte == CH_NUL) begin
                        n_state.drop_rest = 1'b1;
                    end else begin
                        got = 1'b1;
                        dec = i_byte;
                    end
                end
            endcase
            // decoded zero ends the segment output
            if (got && dec == CH_NUL) begin
                got               = 1'b0;
                n_state.drop_rest = 1'b1;
            end
        end
        if (i_last) begin
            n_state = '0;
        end
        o_result.emit       = got || i_last;
        o_result.out_byte   = got ? dec : '0;
        o_result.byte_valid = got;
        o_result.seg_done   = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

    a_clear_after_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_last) |=> (r_state == '0))
        else $error("segment state not cleared after segment end");

endmodule

[sv/mtd_out_reg.sv]
// mtd_out_reg: result register between the decoder and the output channel
// depends on mtd_pkg
module mtd_out_reg import mtd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_result           i_result,
    input  logic              i_out_ready,
    output logic              o_full,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_byte_valid,
    output logic              o_seg_done
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_byte_valid;
    logic              r_seg_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out_byte   <= i_result.out_byte;
            r_byte_valid <= i_result.byte_valid;
            r_seg_done   <= i_result.seg_done;
        end
    end

    assign o_full       = r_valid;
    assign o_out_valid  = r_valid;
    assign o_out_byte   = r_out_byte;
    assign o_byte_valid = r_byte_valid;
    assign o_seg_done   = r_seg_done;

endmodule

[sv/mail_transfer_decoder.sv]
// mail_transfer_decoder: top level with input register, config registers and decoder
// depends on mtd_pkg, mtd_decode and mtd_out_reg
//
// Decodes a byte stream word by word in pass-through, quoted-printable or base64 mode, one
// input word per clock sustained while results are taken: a word is held in the input
// register, is decoded by the single-step logic in mtd_decode and lands in the result register,
// where it is offered to the output. A waiting result that is not taken holds the input
// register, which then holds off the input. Words that decode to nothing (escape introducers,
// base64 first sextets, dropped bytes) give no result; a segment end always gives one, with
// seg_done set. Configuration is written through the plain write port; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module mail_transfer_decoder import mtd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [BYTE_W-1:0]     i_in_byte,
    input  logic                  i_seg_end,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [BYTE_W-1:0]     o_out_byte,
    output logic                  o_byte_valid,
    output logic                  o_seg_done
);

    logic [MODE_W-1:0] r_decode_mode;
    logic              r_underscore_space;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    logic    out_full;
    logic    advance;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode      <= MODE_PASS;
            r_underscore_space <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_DECODE_MODE:      r_decode_mode      <= i_cfg_data[MODE_W-1:0];
                CFG_UNDERSCORE_SPACE: r_underscore_space <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign advance    = r_in_valid && (!out_full || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_seg_end;
        end
    end

    mtd_decode u_decode (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_en               (advance),
        .i_byte             (r_in_byte),
        .i_last             (r_in_last),
        .i_mode             (r_decode_mode),
        .i_underscore_space (r_underscore_space),
        .o_result           (result)
    );

    mtd_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (advance && result.emit),
        .i_result     (result),
        .i_out_ready  (i_out_ready),
        .o_full       (out_full),
        .o_out_valid  (o_out_valid),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_seg_done   (o_seg_done)
    );

    a_no_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_valid) |-> (o_out_byte != CH_NUL))
        else $error("decoded zero byte delivered");

    a_empty_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |-> (o_seg_done && o_out_byte == CH_NUL))
        else $error("empty result that does not close a segment");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_byte)
            && $stable(o_seg_done)))
        else $error("pending result overwritten");

endmodule

[tb/sv/mail_transfer_decoder_tb.sv]
// mail_transfer_decoder_tb: self-checking bench for the mail transfer decoder
// needs mtd_pkg and mail_transfer_decoder; directed escapes and sextets, then random
// segments per mode under varied sender and receiver idling, checked against a byte model
`timescale 1ns / 100ps

module mail_transfer_decoder_tb;
    import mtd_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int PHASE_WORDS  = 160;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;

    typedef struct packed {
        logic [BYTE_W-1:0] code;
        logic              seg_end;
    } t_enc_word;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              valid;
        logic              done;
    } t_dec_result;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic [BYTE_W-1:0]     i_in_byte   = '0;
    logic                  i_seg_end   = 1'b0;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_byte_valid;
    logic                  o_seg_done;

    t_enc_word   words_to_send [$];
    t_dec_result decoded_due [$];
    t_enc_word   next_word;
    t_dec_result due_now;

    // model copy of config and segment state
    logic [MODE_W-1:0] cur_mode   = MODE_PASS;
    logic              cur_us     = 1'b0;
    logic [1:0]        st_phase   = '0;
    logic [5:0]        st_carry   = '0;
    logic [1:0]        st_qp_step = QP_IDLE;
    logic [3:0]        st_hi      = '0;
    logic              st_drop    = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int mismatches     = 0;

    mail_transfer_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .i_seg_end    (i_seg_end),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_seg_done   (o_seg_done)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [4:0] hex_nibble(input logic [BYTE_W-1:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
        return 5'h10;
    endfunction

    function automatic logic [6:0] sextet(input logic [BYTE_W-1:0] c);
        if (c == CH_PLUS) return 7'd62;
        if (c == CH_SLASH) return 7'd63;
        if (c >= "A" && c <= "Z") return 7'(c - "A");
        if (c >= "a" && c <= "z") return 7'(c - "a" + 8'd26);
        if (c >= "0" && c <= "9") return 7'(c - "0" + 8'd52);
        if (c == CH_EQ) return 7'd0;
        return 7'h40;
    endfunction

    function automatic void decode_word(input logic [BYTE_W-1:0] c, input logic seg_end);
        logic [BYTE_W-1:0] b;
        logic              got;
        logic [4:0]        h;
        logic [6:0]        v;
        b   = '0;
        got = 1'b0;
        if (!st_drop) begin
            if (cur_mode == MODE_QP) begin
                case (st_qp_step)
                    QP_AFTER_EQ: begin
                        if (c == CH_LF || c == CH_NUL) begin
                            st_drop    = 1'b1;
                            st_qp_step = QP_IDLE;
                        end else begin
                            h          = hex_nibble(c);
                            st_hi      = h[4] ? 4'hF : h[3:0];
                            st_qp_step = QP_AFTER_HI;
                        end
                    end
                    QP_AFTER_HI: begin
                        st_qp_step = QP_IDLE;
                        if (c == CH_NUL) begin
                            st_drop = 1'b1;
                        end else begin
                            h   = hex_nibble(c);
                            b   = h[4] ? 8'hFF : {st_hi, h[3:0]};
                            got = 1'b1;
                        end
                    end
                    default: begin
                        if (c == CH_NUL) begin
                            st_drop = 1'b1;
                        end else if (c == CH_EQ) begin
                            st_qp_step = QP_AFTER_EQ;
                        end else begin
                            b   = (cur_us && c == CH_UNDER) ? CH_SPACE : c;
                            got = 1'b1;
                        end
                    end
                endcase
            end else if (cur_mode == MODE_B64) begin
                if (c == CH_NUL) begin
                    st_drop = 1'b1;
                end else begin
                    v = sextet(c);
                    if (!v[6]) begin
                        case (st_phase)
                            2'd0: begin
                                st_carry = v[5:0];
                                st_phase = 2'd1;
                            end
                            2'd1: begin
                                b        = {st_carry, v[5:4]};
                                got      = 1'b1;
                                st_carry = {2'b00, v[3:0]};
                                st_phase = 2'd2;
                            end
                            2'd2: begin
                                b        = {st_carry[3:0], v[5:2]};
                                got      = 1'b1;
                                st_carry = {4'b0000, v[1:0]};
                                st_phase = 2'd3;
                            end
                            default: begin
                                b        = {st_carry[1:0], v[5:0]};
                                got      = 1'b1;
                                st_carry = '0;
                                st_phase = 2'd0;
                            end
                        endcase
                    end
                end
            end else if (c == CH_NUL) begin
                st_drop = 1'b1;
            end else begin
                b   = c;
                got = 1'b1;
            end
            if (got && b == CH_NUL) begin
                got     = 1'b0;
                st_drop = 1'b1;
            end
        end
        if (seg_end) begin
            st_phase   = '0;
            st_carry   = '0;
            st_qp_step = QP_IDLE;
            st_hi      = '0;
            st_drop    = 1'b0;
        end
        if (got || seg_end) begin
            decoded_due.push_back('{value: got ? b : 8'h00, valid: got, done: seg_end});
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 100) begin
            $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    function automatic void push_word(input logic [BYTE_W-1:0] c, input logic seg_end);
        words_to_send.push_back('{code: c, seg_end: seg_end});
    endfunction

    function automatic logic [BYTE_W-1:0] pick_hex();
        logic [3:0] n;
        n = 4'($urandom_range(15));
        if (n < 4'd10) return "0" + n;
        if ($urandom_range(1) == 1) return "A" + n - 8'd10;
        return "a" + n - 8'd10;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_sextet();
        int r;
        r = $urandom_range(63);
        if (r < 26) return 8'("A" + r);
        if (r < 52) return 8'("a" + r - 26);
        if (r < 62) return 8'("0" + r - 52);
        if (r == 62) return CH_PLUS;
        return CH_SLASH;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_digit();
        if ($urandom_range(9) == 0) return 8'($urandom_range(255));
        return pick_hex();
    endfunction

    function automatic void add_segment(input logic [MODE_W-1:0] mode, input logic closed);
        logic [BYTE_W-1:0] seg [$];
        int n;
        int k;
        int sel;
        bit cut;
        cut = 0;
        if (mode == MODE_QP) begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n && !cut; k++) begin
                sel = $urandom_range(99);
                if (sel < 45) begin
                    seg.push_back(8'($urandom_range(32, 126)));
                end else if (sel < 55) begin
                    seg.push_back(CH_UNDER);
                end else if (sel < 85) begin
                    seg.push_back(CH_EQ);
                    seg.push_back(pick_digit());
                    seg.push_back(pick_digit());
                    // escape cut short by the segment end
                    if ($urandom_range(15) == 0) begin
                        cut = 1;
                        void'(seg.pop_back());
                        if ($urandom_range(1) == 1) void'(seg.pop_back());
                    end
                end else if (sel < 90) begin
                    seg.push_back(CH_EQ);
                    seg.push_back(CH_LF);
                end else if (sel < 93) begin
                    seg.push_back(CH_NUL);
                end else begin
                    seg.push_back(8'($urandom_range(255)));
                end
            end
        end else if (mode == MODE_B64) begin
            n = $urandom_range(1, 16);
            for (k = 0; k < n; k++) begin
                sel = $urandom_range(99);
                if (sel < 80) seg.push_back(pick_sextet());
                else if (sel < 88) seg.push_back(CH_EQ);
                else if (sel < 92) seg.push_back(CH_LF);
                else if (sel < 96) seg.push_back(CH_SPACE);
                else if (sel < 98) seg.push_back(CH_NUL);
                else seg.push_back(8'($urandom_range(255)));
            end
        end else begin
            n = $urandom_range(1, 10);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(99) < 4) seg.push_back(CH_NUL);
                else seg.push_back(8'($urandom_range(1, 255)));
            end
        end
        for (k = 0; k < seg.size(); k++) begin
            push_word(seg[k], closed && k == seg.size() - 1);
        end
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_DECODE_MODE:      cur_mode = val;
            CFG_UNDERSCORE_SPACE: cur_us   = val[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (words_to_send.size() != 0 || i_in_valid || decoded_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [MODE_W-1:0] mode, input logic us,
                             input int send_pct, input int recv_pct, input bit squeeze);
        write_reg(CFG_DECODE_MODE, mode);
        write_reg(CFG_UNDERSCORE_SPACE, CFG_DATA_W'(us));
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (squeeze) hold_requests++;
        while (words_to_send.size() < PHASE_WORDS) add_segment(mode, 1'b1);
        // last segment may stay open across the next config change
        add_segment(mode, $urandom_range(1) == 1);
        wait_drained();
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                decode_word(i_in_byte, i_seg_end);
            end
            if (!i_in_valid || o_in_ready) begin
                if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = words_to_send.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_byte  <= next_word.code;
                    i_seg_end  <= next_word.seg_end;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (decoded_due.size() == 0) begin
                report_mismatch("unexpected word", o_out_byte, 0);
            end else begin
                due_now = decoded_due.pop_front();
                if (o_out_byte !== due_now.value) begin
                    report_mismatch("out_byte", o_out_byte, due_now.value);
                end
                if (o_byte_valid !== due_now.valid) begin
                    report_mismatch("byte_valid", o_byte_valid, due_now.valid);
                end
                if (o_seg_done !== due_now.done) begin
                    report_mismatch("seg_done", o_seg_done, due_now.done);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("mail_transfer_decoder_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // pass through at reset settings
        @(negedge i_clk);
        push_word(8'hFF, 1'b0);
        push_word(CH_NUL, 1'b0);
        push_word("A", 1'b1);
        wait_drained();

        // quoted-printable escapes and breaks
        write_reg(CFG_DECODE_MODE, MODE_QP);
        write_reg(CFG_UNDERSCORE_SPACE, CFG_DATA_W'(1));
        @(negedge i_clk);
        push_word(CH_UNDER, 1'b0);
        push_word(CH_EQ, 1'b0);
        push_word("g", 1'b0);
        push_word("1", 1'b0);
        push_word(CH_EQ, 1'b0);
        push_word("4", 1'b0);
        push_word("z", 1'b0);
        push_word(CH_EQ, 1'b0);
        push_word(CH_LF, 1'b1);
        push_word(CH_EQ, 1'b0);
        push_word("0", 1'b1);
        push_word(CH_EQ, 1'b0);
        push_word("4", 1'b0);
        push_word(CH_NUL, 1'b1);
        push_word(CH_EQ, 1'b0);
        push_word("0", 1'b0);
        push_word("0", 1'b1);
        push_word(CH_EQ, 1'b0);
        wait_drained();

        // base64 with the escape still open
        write_reg(CFG_DECODE_MODE, MODE_B64);
        @(negedge i_clk);
        push_word(CH_PLUS, 1'b0);
        push_word(CH_SLASH, 1'b0);
        push_word("*", 1'b0);
        push_word(CH_EQ, 1'b0);
        wait_drained();

        write_reg(CFG_DECODE_MODE, MODE_UNUSED);
        @(negedge i_clk);
        push_word("A", 1'b0);
        wait_drained();

        // finish the pending escape
        write_reg(CFG_DECODE_MODE, MODE_QP);
        write_reg(CFG_UNDERSCORE_SPACE, CFG_DATA_W'(0));
        @(negedge i_clk);
        push_word("4", 1'b0);
        push_word("1", 1'b0);
        push_word(CH_UNDER, 1'b1);
        wait_drained();

        run_phase(MODE_QP,     1'b0,  0,  0, 1'b0);
        run_phase(MODE_B64,    1'b0, 66,  0, 1'b0);
        run_phase(MODE_PASS,   1'b1,  0, 66, 1'b0);
        run_phase(MODE_QP,     1'b1, 12, 12, 1'b0);
        run_phase(MODE_UNUSED, 1'b0,  0,  0, 1'b1);
        run_phase(MODE_B64,    1'b1,  0, 66, 1'b0);
        run_phase(MODE_QP,     1'b1, 66,  0, 1'b0);
        run_phase(MODE_B64,    1'b0, 12, 12, 1'b0);
        run_phase(MODE_QP,     1'b0,  0, 66, 1'b0);

        if (mismatches == 0) begin
            $display("mail_transfer_decoder_tb: done, clean");
        end else begin
            $display("mail_transfer_decoder_tb: done, errors");
        end
        $finish;
    end

endmodule
